FILE: src/kmsr_pkg.sv
// Shared types, constants and helper functions for the key matrix serial reporter.
// Depends on nothing; every other file of the block uses it by scoped names.
package kmsr_pkg;

  localparam int NUM_ROWS_DEF    = 15;
  localparam int FRAME_TICKS_DEF = 64;
  localparam int ROW_W           = 4;
  localparam int BIT_W           = 3;
  localparam int DATA_W          = 8;
  localparam int FRAME_W         = 14;
  localparam int FRAME_BITS      = 14;
  localparam int SPECIAL_ROW     = 14;
  localparam logic [DATA_W-1:0] ROW_RESET     = 8'hff;
  localparam logic [DATA_W-1:0] SPECIAL_RESET = 8'h7f;

  typedef enum logic [1:0] {
    REQ_FLIP  = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_RESET = 2'd2,
    REQ_TICK  = 2'd3
  } req_e_t;

  typedef struct packed {
    req_e_t           req;
    logic [ROW_W-1:0] row;
    logic [BIT_W-1:0] key_bit;
    logic             pressed;
    logic             bad;
  } cmd_t;

  function automatic logic [DATA_W-1:0] row_reset(input logic [ROW_W:0] r);
    logic [DATA_W-1:0] v;
    v = (r == (ROW_W+1)'(SPECIAL_ROW)) ? SPECIAL_RESET : ROW_RESET;
    return v;
  endfunction

  // Start bit, row, data and even parity over row and data, LSB first.
  function automatic logic [FRAME_W-1:0] build_frame(input logic [ROW_W-1:0] row,
                                                     input logic [DATA_W-1:0] data);
    logic par;
    par = ^{data, row};
    return {par, data, row, 1'b0};
  endfunction

endpackage

FILE: src/kmsr_front.sv
// Front end: takes request words from the command port and classifies them.
// Depends on kmsr_pkg; feeds kmsr_fifo.
module kmsr_front #(
  parameter int NUM_ROWS = kmsr_pkg::NUM_ROWS_DEF
) (
  input  logic                           start,
  input  logic [1:0]                     in_req_type,
  input  logic [kmsr_pkg::ROW_W-1:0]     in_key_row,
  input  logic [kmsr_pkg::BIT_W-1:0]     in_key_bit,
  input  logic                           in_pressed,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           push,
  output kmsr_pkg::cmd_t                 cmd
);

  kmsr_pkg::req_e_t req;

  always_comb begin
    req         = kmsr_pkg::req_e_t'(in_req_type);
    cmd.req     = req;
    cmd.row     = in_key_row;
    cmd.key_bit = in_key_bit;
    cmd.pressed = in_pressed;
    cmd.bad     = (req == kmsr_pkg::REQ_FLIP) &&
                  ({1'b0, in_key_row} >= (kmsr_pkg::ROW_W+1)'(NUM_ROWS));
  end

  assign busy = q_full;
  assign push = start && !q_full;

endmodule

FILE: src/kmsr_fifo.sv
// Two-entry queue of classified request words between the front and back ends.
// Depends on kmsr_pkg for the word type.
module kmsr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kmsr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output kmsr_pkg::cmd_t head_cmd
);

  kmsr_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  always_comb begin
    do_push    = push && (count_r != 2'd2);
    do_pop     = pop && (count_r != 2'd0);
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_cmd  = mem_r[rd_ptr_r];

endmodule

FILE: src/kmsr_back.sv
// Back end: key matrix, dirty flags, flush scan and serial frame transmitter.
// Depends on kmsr_pkg; executes one word from kmsr_fifo per cycle.
module kmsr_back #(
  parameter int NUM_ROWS    = kmsr_pkg::NUM_ROWS_DEF,
  parameter int FRAME_TICKS = kmsr_pkg::FRAME_TICKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  kmsr_pkg::cmd_t cmd,
  output logic           out_valid,
  output logic           out_line_level,
  output logic           out_busy_res,
  output logic           out_bad_row
);

  localparam int TC_W  = $clog2(FRAME_TICKS);
  localparam int ROW_W = kmsr_pkg::ROW_W;

  logic [kmsr_pkg::DATA_W-1:0]  rows_r [NUM_ROWS];
  logic [kmsr_pkg::DATA_W-1:0]  rows_nxt [NUM_ROWS];
  logic [NUM_ROWS-1:0]          dirty_r, dirty_nxt;
  logic [TC_W-1:0]              tc_r, tc_nxt;
  logic [kmsr_pkg::FRAME_W-1:0] fs_r, fs_nxt;
  logic                         scan_r, scan_nxt;
  logic [ROW_W-1:0]             next_r, next_nxt;
  logic                         line_r, line_nxt;
  logic                         out_valid_r, bad_r;
  logic [kmsr_pkg::DATA_W-1:0]  cur_row;
  logic [TC_W:0]                tc_inc;
  logic                         do_adv, hit;
  logic [ROW_W-1:0]             hit_row;

  always_comb begin
    rows_nxt  = rows_r;
    dirty_nxt = dirty_r;
    tc_nxt    = tc_r;
    fs_nxt    = fs_r;
    scan_nxt  = scan_r;
    next_nxt  = next_r;
    line_nxt  = line_r;
    cur_row   = kmsr_pkg::ROW_RESET;
    tc_inc    = '0;
    do_adv    = 1'b0;
    hit       = 1'b0;
    hit_row   = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (cmd.row == ROW_W'(r)) begin
        cur_row = rows_r[r];
      end
    end
    if (cmd_valid) begin
      case (cmd.req)
        kmsr_pkg::REQ_FLIP: begin
          if (!cmd.bad && ((!cur_row[cmd.key_bit]) != cmd.pressed)) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
              if (cmd.row == ROW_W'(r)) begin
                dirty_nxt[r]             = 1'b1;
                rows_nxt[r][cmd.key_bit] = !cmd.pressed;
              end
            end
          end
        end
        kmsr_pkg::REQ_FLUSH: begin
          scan_nxt = 1'b1;
          next_nxt = '0;
          do_adv   = 1'b1;
        end
        kmsr_pkg::REQ_RESET: begin
          for (int r = 0; r < NUM_ROWS; r++) begin
            rows_nxt[r] = kmsr_pkg::row_reset((ROW_W+1)'(r));
          end
        end
        kmsr_pkg::REQ_TICK: begin
          if (tc_r != '0) begin
            if (tc_r <= TC_W'(kmsr_pkg::FRAME_BITS)) begin
              line_nxt = fs_r[0];
              fs_nxt   = fs_r >> 1;
            end else begin
              line_nxt = 1'b1;
            end
            tc_inc = {1'b0, tc_r} + (TC_W+1)'(1);
            tc_nxt = (tc_inc >= (TC_W+1)'(FRAME_TICKS)) ? '0 : tc_inc[TC_W-1:0];
            do_adv = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // The lowest dirty row at or above the scan pointer wins.
    if (do_adv && scan_nxt && (tc_nxt == '0)) begin
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
        if (dirty_r[r] && ((ROW_W+1)'(r) >= {1'b0, next_nxt})) begin
          hit     = 1'b1;
          hit_row = ROW_W'(r);
        end
      end
      if (hit) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (hit_row == ROW_W'(r)) begin
            dirty_nxt[r] = 1'b0;
            fs_nxt       = kmsr_pkg::build_frame(hit_row, rows_r[r]);
          end
        end
        tc_nxt = TC_W'(1);
        if (({1'b0, hit_row} + (ROW_W+1)'(1)) < (ROW_W+1)'(NUM_ROWS)) begin
          next_nxt = hit_row + ROW_W'(1);
        end else begin
          scan_nxt = 1'b0;
          next_nxt = '0;
        end
      end else begin
        scan_nxt = 1'b0;
        next_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_r[r] <= kmsr_pkg::row_reset((ROW_W+1)'(r));
      end
      dirty_r     <= '0;
      tc_r        <= '0;
      fs_r        <= '0;
      scan_r      <= 1'b0;
      next_r      <= '0;
      line_r      <= 1'b1;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      dirty_r     <= dirty_nxt;
      tc_r        <= tc_nxt;
      fs_r        <= fs_nxt;
      scan_r      <= scan_nxt;
      next_r      <= next_nxt;
      line_r      <= line_nxt;
      out_valid_r <= cmd_valid;
      bad_r       <= cmd_valid && cmd.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = line_r;
  assign out_busy_res   = (tc_r != '0) || scan_r;
  assign out_bad_row    = bad_r;

  a_scan_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r |-> (tc_r != '0))
    else $error("scan pending without a frame period");

  a_idle_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    !scan_r |-> (next_r == '0))
    else $error("scan pointer not cleared after scan end");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    (tc_r == '0) |-> line_r)
    else $error("serial line low outside a frame period");

  a_bad_only_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && (cmd.req != kmsr_pkg::REQ_FLIP)) |=> !bad_r)
    else $error("bad row flagged for a non-flip word");

endmodule

FILE: src/key_matrix_serial_reporter.sv
// Top level of the key matrix serial reporter.
// Depends on kmsr_pkg, kmsr_front, kmsr_fifo and kmsr_back.
//
// Usage: a request word (in_req_type, in_key_row, in_key_bit, in_pressed) is
// taken at a rising edge where start is high and busy is low. Words are flips
// of single keys, flush requests, matrix restores and serial bit ticks.
// The front end classifies each word and places it in a two-entry queue; the
// back end executes one word per cycle, so busy rises only if the queue fills.
// Every word gives exactly one result word: out_valid is high for one cycle
// with out_line_level, out_busy_res and out_bad_row. A word is written to the
// queue at the accepting edge, executed from its head, and its result is
// registered in the back end before reaching the ports. One word per cycle is
// sustained; the back end's update of the matrix, dirty flags and frame
// shifter sets that rate; the dirty row search is a priority pick over flags.
// The receiver cannot hold results off, and none are ever dropped.
// Reset (rst_n low, synchronous) restores the matrix, clears dirty flags and
// the queue, and drives the serial line high. No clearing pass is needed.
module key_matrix_serial_reporter #(
  parameter int NUM_ROWS    = kmsr_pkg::NUM_ROWS_DEF,
  parameter int FRAME_TICKS = kmsr_pkg::FRAME_TICKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_req_type,
  input  logic [kmsr_pkg::ROW_W-1:0] in_key_row,
  input  logic [kmsr_pkg::BIT_W-1:0] in_key_bit,
  input  logic                       in_pressed,
  output logic                       out_valid,
  output logic                       out_line_level,
  output logic                       out_busy_res,
  output logic                       out_bad_row
);

  kmsr_pkg::cmd_t push_cmd, head_cmd;
  logic           push, q_full, q_not_empty;

  kmsr_front #(
    .NUM_ROWS(NUM_ROWS)
  ) u_front (
    .start      (start),
    .in_req_type(in_req_type),
    .in_key_row (in_key_row),
    .in_key_bit (in_key_bit),
    .in_pressed (in_pressed),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  kmsr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_not_empty),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_cmd (head_cmd)
  );

  kmsr_back #(
    .NUM_ROWS   (NUM_ROWS),
    .FRAME_TICKS(FRAME_TICKS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_not_empty),
    .cmd           (head_cmd),
    .out_valid     (out_valid),
    .out_line_level(out_line_level),
    .out_busy_res  (out_busy_res),
    .out_bad_row   (out_bad_row)
  );

endmodule
